// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the odometry RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked each clock, off during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Types, constants and helpers of the differential drive odometry core.
// ----------------------------------------------------------------------------
`default_nettype none
package ddo_pkg;

    localparam int CORDIC_STEPS   = 24;
    localparam int POSE_FRAC_BITS = 24;
    localparam int DIST_FRAC      = 25;
    localparam int STEP_W         = $clog2(CORDIC_STEPS + 1);
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 31;

    localparam logic [CFG_IDX_W-1:0] REG_TICK_DISTANCE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INV_TRACK_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ENCODER_ONLY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUMP_THRESHOLD  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_IMU_PERIOD      = 3'd4;

    localparam logic [63:0] RAD_TO_BAM_Q24  = 64'd683565276;
    localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;
    localparam logic signed [47:0] POSE_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic signed [47:0] POSE_MIN = 48'sh8000_0000_0000;

    typedef struct packed {
        logic signed [31:0] left_count;
        logic signed [31:0] right_count;
        logic signed [31:0] imu_rate;
    } t_in_item;

    typedef struct packed {
        logic signed [47:0] pose_x;
        logic signed [47:0] pose_y;
        logic [31:0]        heading;
        logic               jump_seen;
    } t_out_item;

    // Classified work handed from front to back.
    typedef struct packed {
        logic signed [32:0] dl;
        logic signed [32:0] dr;
        logic signed [31:0] imu_rate;
        logic               jump;
    } t_work;

    typedef struct packed {
        logic [23:0] tick_distance;
        logic [19:0] inv_track_width;
        logic        encoder_only;
        logic [30:0] jump_threshold;
        logic [23:0] imu_period;
    } t_cfg;

    function automatic logic [31:0] atan_bam(input logic [4:0] i);
        logic [31:0] v;
        begin
            unique case (i)
                5'd0:  v = 32'h20000000;  5'd1:  v = 32'h12E4051E;
                5'd2:  v = 32'h09FB385B;  5'd3:  v = 32'h051111D4;
                5'd4:  v = 32'h028B0D43;  5'd5:  v = 32'h0145D7E1;
                5'd6:  v = 32'h00A2F61E;  5'd7:  v = 32'h00517C55;
                5'd8:  v = 32'h0028BE53;  5'd9:  v = 32'h00145F2F;
                5'd10: v = 32'h000A2F98;  5'd11: v = 32'h000517CC;
                5'd12: v = 32'h00028BE6;  5'd13: v = 32'h000145F3;
                5'd14: v = 32'h0000A2FA;  5'd15: v = 32'h0000517D;
                5'd16: v = 32'h000028BE;  5'd17: v = 32'h0000145F;
                5'd18: v = 32'h00000A30;  5'd19: v = 32'h00000518;
                5'd20: v = 32'h0000028C;  5'd21: v = 32'h00000146;
                5'd22: v = 32'h000000A3;  5'd23: v = 32'h00000051;
                5'd24: v = 32'h00000029;  5'd25: v = 32'h00000014;
                5'd26: v = 32'h0000000A;  5'd27: v = 32'h00000005;
                5'd28: v = 32'h00000003;  5'd29: v = 32'h00000001;
                5'd30: v = 32'h00000001;  default: v = 32'h00000000;
            endcase
            return v;
        end
    endfunction

endpackage
`default_nettype wire

// ===== rtl/ddo_stream_if.sv =====
// ----------------------------------------------------------------------------
// ddo_stream_if
// Valid/ready channel carrying one payload of the given type.
// ----------------------------------------------------------------------------
`default_nettype none
interface ddo_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/ddo_front.sv =====
// ----------------------------------------------------------------------------
// ddo_front
// Accepts samples, primes stored counts, forms deltas and applies the jump test.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ddo_front
    import ddo_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic [30:0] i_jump_threshold,
    ddo_stream_if.sink       s_in,
    output logic             o_work_valid,
    output t_work            o_work,
    input  wire logic        i_work_ready
);
    logic        r_primed;
    logic [31:0] r_last_left, r_last_right;
    logic        r_valid;
    t_work       r_work;
    logic [31:0] dl, dr, ml, mr;
    logic        jump, accept;

    assign s_in.ready = !r_valid || i_work_ready;
    assign accept     = s_in.valid && s_in.ready;

    always_comb begin
        dl   = s_in.data.left_count - r_last_left;
        dr   = r_last_right - s_in.data.right_count;
        ml   = dl[31] ? (~dl + 32'd1) : dl;
        mr   = dr[31] ? (~dr + 32'd1) : dr;
        jump = (ml > {1'b0, i_jump_threshold}) || (mr > {1'b0, i_jump_threshold});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed     <= 1'b0;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_valid      <= 1'b0;
        end else begin
            if (accept && r_primed) begin
                r_valid <= 1'b1;
            end else if (i_work_ready) begin
                r_valid <= 1'b0;
            end
            if (accept) begin
                r_last_left  <= s_in.data.left_count;
                r_last_right <= s_in.data.right_count;
                r_primed     <= 1'b1;
                if (r_primed) begin
                    r_work.jump   <= jump;
                    r_work.dl     <= jump ? '0 : {dl[31], dl};
                    r_work.dr     <= jump ? '0 : {dr[31], dr};
                    r_work.imu_rate <= s_in.data.imu_rate;
                end
            end
        end
    end

    assign o_work_valid = r_valid;
    assign o_work       = r_work;

    `ASSERT_IMPL(a_jump_zero, i_clk, i_rst_n, r_valid && r_work.jump,
        r_work.dl == '0 && r_work.dr == '0, "jump item carries nonzero delta")
    `ASSERT_NEXT(a_prime_first, i_clk, i_rst_n, accept && !r_primed && !r_valid,
        !r_valid && r_primed, "priming item produced work")
    `ASSERT_NEXT(a_work_hold, i_clk, i_rst_n, r_valid && !i_work_ready,
        r_valid && $stable(r_work), "work changed while stalled")
endmodule
`default_nettype wire

// ===== rtl/ddo_back.sv =====
// ----------------------------------------------------------------------------
// ddo_back
// Yaw step, CORDIC rotation, gain correction and saturating pose update.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module ddo_back
    import ddo_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire t_cfg  i_cfg,
    input  wire logic  i_work_valid,
    input  wire t_work i_work,
    output logic       o_work_ready,
    ddo_stream_if.source m_out
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_BAM   = 4'd3;
    localparam logic [3:0] S_ROT0  = 4'd4;
    localparam logic [3:0] S_ITER  = 4'd5;
    localparam logic [3:0] S_GX0   = 4'd6;
    localparam logic [3:0] S_GX1   = 4'd7;
    localparam logic [3:0] S_GY0   = 4'd8;
    localparam logic [3:0] S_GY1   = 4'd9;
    localparam logic [3:0] S_ACC   = 4'd10;
    localparam logic [3:0] S_OUT   = 4'd11;

    logic [3:0]  r_state, n_state;
    t_work       r_w;
    logic signed [63:0] r_v, r_q40, r_x, r_y;
    logic signed [63:0] r_step;
    logic [31:0] r_z, r_heading;
    logic [STEP_W-1:0] r_i;
    logic signed [47:0] r_acc_x, r_acc_y;
    logic [63:0] r_p;
    logic signed [33:0] r_t;

    // Shared 32x32 unsigned multiplier.
    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = 64'(mul_a) * 64'(mul_b);

    function automatic logic signed [63:0] fshr(input logic signed [63:0] x,
                                                input logic [5:0] s);
        return x >>> s;
    endfunction

    function automatic logic signed [63:0] clamp(input logic signed [63:0] x,
                                                 input logic signed [63:0] lo,
                                                 input logic signed [63:0] hi);
        return (x < lo) ? lo : ((x > hi) ? hi : x);
    endfunction

    function automatic logic signed [63:0] to_pose(input logic signed [63:0] x);
        logic signed [63:0] t;
        begin
            if (POSE_FRAC_BITS >= DIST_FRAC) begin
                t = clamp(x, -(64'sd1 <<< (48 - (POSE_FRAC_BITS - DIST_FRAC))),
                          64'sd1 <<< (48 - (POSE_FRAC_BITS - DIST_FRAC)));
                t = t <<< (POSE_FRAC_BITS - DIST_FRAC);
            end else begin
                t = x >>> (DIST_FRAC - POSE_FRAC_BITS);
            end
            return clamp(t, -(64'sd1 <<< 48), 64'sd1 <<< 48);
        end
    endfunction

    logic signed [63:0] gsrc;
    logic [63:0] gm, gsum;
    logic signed [63:0] q24, zs;
    logic signed [62:0] bamp;
    logic signed [58:0] v_prod;
    logic [31:0] mag_t;
    logic [43:0] hi_p;
    logic [64:0] wide_p;
    logic [62:0] wheel_r;

    assign gsrc  = (r_state == S_GX0 || r_state == S_GX1) ? r_x : r_y;
    assign gm    = gsrc[63] ? (~gsrc + 64'd1) : gsrc;
    assign gsum  = r_p + (mul_p >> 32);
    assign mag_t = r_t[33] ? 32'(~r_t + 34'd1) : 32'(r_t);
    assign v_prod = $signed(r_v[33:0]) * $signed({1'b0, i_cfg.tick_distance});

    // Upper part of |t| * p, where p = tick * reciprocal is up to 44 bits.
    assign hi_p    = 44'(mag_t) * 44'(r_p[43:32]);
    assign wide_p  = 65'({hi_p[29:0], 32'd0}) + 65'(mul_p);
    assign wheel_r = (hi_p[43:30] != '0 || wide_p > 65'h0_4000_0000_0000_0000)
                   ? 63'h4000_0000_0000_0000 : wide_p[62:0];

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            S_MUL1: begin
                mul_a = 32'(r_w.imu_rate[31] ? (~r_w.imu_rate + 32'd1) : r_w.imu_rate);
                mul_b = {8'd0, i_cfg.imu_period};
                if (i_cfg.encoder_only) begin
                    mul_a = {8'd0, i_cfg.tick_distance};
                    mul_b = {12'd0, i_cfg.inv_track_width};
                end
            end
            S_MUL2: begin
                mul_a = mag_t;
                mul_b = r_p[31:0];
            end
            S_GX0, S_GY0: begin
                mul_a = gm[63:32];
                mul_b = CORDIC_GAIN_Q32;
            end
            S_GX1, S_GY1: begin
                mul_a = gm[31:0];
                mul_b = CORDIC_GAIN_Q32;
            end
            default: begin
                mul_a = '0;
            end
        endcase
    end

    always_comb begin
        q24  = clamp((r_q40 + 64'sd32768) >>> 16, -64'sd2147483648, 64'sd2147483647);
        bamp = $signed(q24[31:0]) * $signed({1'b0, RAD_TO_BAM_Q24[29:0]});
        zs   = 64'($signed(r_z));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (i_work_valid) n_state = S_MUL1;
            S_MUL1: n_state = i_cfg.encoder_only ? S_MUL2 : S_BAM;
            S_MUL2: n_state = S_BAM;
            S_BAM:  n_state = S_ROT0;
            S_ROT0: n_state = S_ITER;
            S_ITER: if (r_i == STEP_W'(CORDIC_STEPS - 1)) n_state = S_GX0;
            S_GX0:  n_state = S_GX1;
            S_GX1:  n_state = S_GY0;
            S_GY0:  n_state = S_GY1;
            S_GY1:  n_state = S_ACC;
            S_ACC:  n_state = S_OUT;
            S_OUT:  if (m_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_work_ready = (r_state == S_IDLE);
    assign m_out.valid  = (r_state == S_OUT);
    assign m_out.data   = '{pose_x: r_acc_x, pose_y: r_acc_y, heading: r_heading,
                            jump_seen: r_w.jump};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_acc_x   <= '0;
            r_acc_y   <= '0;
            r_heading <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (i_work_valid) begin
                        r_w <= i_work;
                        r_t <= 34'(i_work.dr) - 34'(i_work.dl);
                        r_v <= 64'(34'(i_work.dl) + 34'(i_work.dr));
                    end
                end
                S_MUL1: begin
                    r_v <= 64'(v_prod);
                    r_p <= mul_p;
                    if (!i_cfg.encoder_only) begin
                        r_q40 <= r_w.imu_rate[31] ? $signed(mul_p) : -$signed(mul_p);
                    end
                end
                S_MUL2: begin
                    r_q40 <= r_t[33] ? -$signed(64'(wheel_r)) : $signed(64'(wheel_r));
                end
                S_BAM: begin
                    r_step <= 64'((bamp + 63'sd8388608) >>> 24);
                end
                S_ROT0: begin
                    r_z <= r_heading + 32'(r_step >>> 1);
                    r_heading <= r_heading + r_step[31:0];
                    r_i <= '0;
                    r_y <= '0;
                    r_x <= r_v;
                end
                S_ITER: begin
                    r_i <= r_i + 1'b1;
                    begin : step_blk
                        logic signed [63:0] x0, z0, nz;
                        x0 = r_x;
                        z0 = zs;
                        if (r_i == '0) begin
                            if (zs > 64'sd1073741824) begin
                                z0 = zs - 64'sd2147483648; x0 = -r_x;
                            end else if (zs < -64'sd1073741824) begin
                                z0 = zs + 64'sd2147483648; x0 = -r_x;
                            end
                        end
                        if (z0 >= 0) begin
                            r_x <= x0 - fshr(r_y, 6'(r_i));
                            r_y <= r_y + fshr(x0, 6'(r_i));
                            nz = z0 - 64'(atan_bam(5'(r_i)));
                        end else begin
                            r_x <= x0 + fshr(r_y, 6'(r_i));
                            r_y <= r_y - fshr(x0, 6'(r_i));
                            nz = z0 + 64'(atan_bam(5'(r_i)));
                        end
                        r_z <= nz[31:0];
                    end
                end
                S_GX0: begin
                    r_p <= mul_p;
                end
                S_GX1: begin
                    r_x <= r_x[63] ? -$signed(gsum) : $signed(gsum);
                end
                S_GY0: begin
                    r_p <= mul_p;
                end
                S_GY1: begin
                    r_y <= r_y[63] ? -$signed(gsum) : $signed(gsum);
                end
                S_ACC: begin
                    r_acc_x <= 48'(clamp(64'(r_acc_x) + to_pose(r_x), 64'(POSE_MIN),
                                         64'(POSE_MAX)));
                    r_acc_y <= 48'(clamp(64'(r_acc_y) + to_pose(r_y), 64'(POSE_MIN),
                                         64'(POSE_MAX)));
                end
                S_OUT: begin
                end
                default: begin
                end
            endcase
        end
    end

    `ASSERT_IMPL(a_out_hold, i_clk, i_rst_n, m_out.valid && !m_out.ready,
        !o_work_ready, "back end took work while result pending")
    `ASSERT_NEXT(a_iter_cnt, i_clk, i_rst_n, r_state == S_ITER,
        r_state == S_ITER || r_state == S_GX0, "CORDIC loop left early")
    `ASSERT_NEXT(a_out_stable, i_clk, i_rst_n, m_out.valid && !m_out.ready,
        m_out.valid && $stable(m_out.data), "pending result changed")
endmodule
`default_nettype wire

// ===== rtl/diff_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// diff_drive_odometry_core
// Dead-reckoning odometry for a differential drive base.
// ----------------------------------------------------------------------------
// Each accepted sample leaves its wheel counts in the front stage; every
// sample after the first yields one pose. The back end works on one sample
// at a time and takes new work only when idle, after its pose has left the
// output; the 24-step iterative CORDIC and the shared 32x32 multiplier used
// for yaw step and gain correction set its pace. The front stage holds one
// formed work item while the back end is busy.
`default_nettype none
module diff_drive_odometry_core
    import ddo_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    ddo_stream_if.sink                 s_in,
    ddo_stream_if.source               m_out
);
    t_cfg  r_cfg;
    t_work work;
    logic  work_valid, work_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '{tick_distance: 24'd34561, inv_track_width: 20'd42010,
                       encoder_only: 1'b0, jump_threshold: 31'd5000,
                       imu_period: 24'd335544};
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_TICK_DISTANCE:   r_cfg.tick_distance   <= i_cfg_data[23:0];
                REG_INV_TRACK_WIDTH: r_cfg.inv_track_width <= i_cfg_data[19:0];
                REG_ENCODER_ONLY:    r_cfg.encoder_only    <= i_cfg_data[0];
                REG_JUMP_THRESHOLD:  r_cfg.jump_threshold  <= i_cfg_data[30:0];
                REG_IMU_PERIOD:      r_cfg.imu_period      <= i_cfg_data[23:0];
                default: begin
                end
            endcase
        end
    end

    ddo_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_jump_threshold (r_cfg.jump_threshold),
        .s_in             (s_in),
        .o_work_valid     (work_valid),
        .o_work           (work),
        .i_work_ready     (work_ready)
    );

    ddo_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_work_valid (work_valid),
        .i_work       (work),
        .o_work_ready (work_ready),
        .m_out        (m_out)
    );
endmodule
`default_nettype wire

// ===== test/tb_diff_drive_odometry_core.sv =====
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_core
// Self-checking bench for the odometry core: encoder/IMU requests with random
// gaps on both channels, a bit-exact pose predictor, and phases that move the
// configuration through its extremes between drained stretches of traffic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module tb_diff_drive_odometry_core;
    import ddo_pkg::*;

    localparam int  IDLE_WAIT   = 120;
    localparam int  CYCLE_LIMIT = 2000000;
    localparam longint SAT62    = 64'sh4000_0000_0000_0000;
    localparam longint LIM48    = 64'sh0001_0000_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    ddo_stream_if #(.T(t_in_item))  in_ch();
    ddo_stream_if #(.T(t_out_item)) out_ch();

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        out_ch.ready = 1'b0;
    end

    diff_drive_odometry_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .s_in(in_ch), .m_out(out_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor state and register copies
    logic [23:0] tick_q = 24'd34561;
    logic [19:0] inv_tw_q = 20'd42010;
    logic        enc_only_q = 1'b0;
    logic [30:0] jump_thr_q = 31'd5000;
    logic [23:0] imu_per_q = 24'd335544;
    logic        primed_q = 1'b0;
    logic [31:0] prev_left = '0, prev_right = '0, heading_acc = '0;
    longint      pose_x_acc = 0, pose_y_acc = 0;

    logic [31:0] arctan_bam [32] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001,
        32'h00000001, 32'h00000000};

    t_in_item  sample_q [$];
    t_out_item pose_q [$];
    int        mismatches = 0;
    int        cycles = 0;

    function automatic longint abs64(longint x);
        return x < 0 ? -x : x;
    endfunction

    function automatic longint gain_fix(longint x);
        longint unsigned m, r;
        m = abs64(x);
        r = (m >> 32) * 64'(CORDIC_GAIN_Q32)
            + (((m & 64'hFFFF_FFFF) * 64'(CORDIC_GAIN_Q32)) >> 32);
        return x < 0 ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint dist_to_pose(longint x);
        longint p;
        p = x >>> (DIST_FRAC - POSE_FRAC_BITS);
        return p < -LIM48 ? -LIM48 : (p > LIM48 ? LIM48 : p);
    endfunction

    function automatic longint sat_pose(longint x);
        return x < longint'(POSE_MIN) ? longint'(POSE_MIN)
             : (x > longint'(POSE_MAX) ? longint'(POSE_MAX) : x);
    endfunction

    task automatic advance_pose(input t_in_item it);
        logic signed [31:0] d32, ang;
        longint dl, dr, v, q40, q24, stp, t, z, x, y, nx;
        longint unsigned p, m, r;
        logic jump;
        if (!primed_q) begin
            prev_left = it.left_count;
            prev_right = it.right_count;
            primed_q = 1'b1;
            return;
        end
        d32 = it.left_count - prev_left;
        dl = d32;
        d32 = prev_right - it.right_count;
        dr = d32;
        jump = (abs64(dl) > longint'(jump_thr_q)) || (abs64(dr) > longint'(jump_thr_q));
        if (jump) begin
            dl = 0;
            dr = 0;
        end
        prev_left = it.left_count;
        prev_right = it.right_count;
        v = (dl + dr) * longint'(tick_q);
        if (enc_only_q) begin
            t = dr - dl;
            p = 64'(tick_q) * 64'(inv_tw_q);
            m = abs64(t);
            if (p == 0 || m == 0) r = 0;
            else if (m > 64'(SAT62) / p) r = 64'(SAT62);
            else r = m * p;
            q40 = t < 0 ? -longint'(r) : longint'(r);
        end else begin
            q40 = -(longint'(it.imu_rate) * longint'(imu_per_q));
        end
        q24 = (q40 + 32768) >>> 16;
        if (q24 > 64'sd2147483647) q24 = 64'sd2147483647;
        if (q24 < -64'sd2147483648) q24 = -64'sd2147483648;
        stp = (q24 * longint'(RAD_TO_BAM_Q24) + 8388608) >>> 24;
        ang = heading_acc + 32'(stp >>> 1);
        z = ang;
        if (z > 64'sd1073741824) begin
            z -= 64'sd2147483648;
            v = -v;
        end else if (z < -64'sd1073741824) begin
            z += 64'sd2147483648;
            v = -v;
        end
        x = v;
        y = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= longint'(arctan_bam[i]);
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += longint'(arctan_bam[i]);
            end
            x = nx;
        end
        heading_acc = heading_acc + 32'(stp);
        pose_x_acc = sat_pose(pose_x_acc + dist_to_pose(gain_fix(x)));
        pose_y_acc = sat_pose(pose_y_acc + dist_to_pose(gain_fix(y)));
        pose_q.push_back('{pose_x: pose_x_acc[47:0], pose_y: pose_y_acc[47:0],
                           heading: heading_acc, jump_seen: jump});
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(99);
        if (k < 60) return 0;
        if (k < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // driver
    int src_gap = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else begin
            if (in_ch.valid && in_ch.ready) advance_pose(in_ch.data);
            if (!in_ch.valid || in_ch.ready) begin
                if (src_gap > 0) begin
                    src_gap <= src_gap - 1;
                    in_ch.valid <= 1'b0;
                end else if (sample_q.size() != 0) begin
                    in_ch.data <= sample_q.pop_front();
                    in_ch.valid <= 1'b1;
                    src_gap <= pick_gap();
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    int snk_gap = 0;
    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            if (out_ch.valid && out_ch.ready) begin
                got = out_ch.data;
                if (pose_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected pose: x=%h y=%h hd=%h j=%b",
                                 got.pose_x, got.pose_y, got.heading, got.jump_seen);
                end else begin
                    want = pose_q.pop_front();
                    if (got.pose_x !== want.pose_x || got.pose_y !== want.pose_y ||
                        got.heading !== want.heading || got.jump_seen !== want.jump_seen) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("pose mismatch: exp x=%h y=%h hd=%h j=%b",
                                     want.pose_x, want.pose_y, want.heading, want.jump_seen,
                                     " got x=%h y=%h hd=%h j=%b",
                                     got.pose_x, got.pose_y, got.heading, got.jump_seen);
                    end
                end
            end
            if (snk_gap > 0) begin
                snk_gap <= snk_gap - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
                snk_gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // stimulus
    logic [31:0] gen_left = '0, gen_right = '0;

    task automatic queue_sample(input logic [31:0] l, input logic [31:0] r,
                                input logic [31:0] rate);
        gen_left = l;
        gen_right = r;
        sample_q.push_back('{left_count: l, right_count: r, imu_rate: rate});
    endtask

    task automatic drain_wait();
        while (sample_q.size() != 0 || in_ch.valid || pose_q.size() != 0)
            @(posedge i_clk);
        repeat (IDLE_WAIT) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [30:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_TICK_DISTANCE:   tick_q = val[23:0];
            REG_INV_TRACK_WIDTH: inv_tw_q = val[19:0];
            REG_ENCODER_ONLY:    enc_only_q = val[0];
            REG_JUMP_THRESHOLD:  jump_thr_q = val;
            REG_IMU_PERIOD:      imu_per_q = val[23:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic write_all(input logic [23:0] tick, input logic [19:0] inv,
                             input logic enc, input logic [30:0] thr,
                             input logic [23:0] per);
        write_reg(REG_TICK_DISTANCE, 31'(tick));
        write_reg(REG_INV_TRACK_WIDTH, 31'(inv));
        write_reg(REG_ENCODER_ONLY, 31'(enc));
        write_reg(REG_JUMP_THRESHOLD, thr);
        write_reg(REG_IMU_PERIOD, 31'(per));
    endtask

    function automatic logic [31:0] pick_rate();
        int k;
        k = $urandom_range(9);
        if (k < 6) return 32'($signed($urandom_range(400000)) - 200000);
        if (k < 9) return $urandom;
        return k[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    task automatic random_samples(input int n);
        int k, span;
        logic [31:0] dl, dr;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            span = (jump_thr_q > 31'd6000) ? 6000 : int'(jump_thr_q) + 2;
            if (k < 80) begin
                dl = 32'($signed($urandom_range(2 * span)) - span);
                dr = 32'($signed($urandom_range(2 * span)) - span);
                queue_sample(gen_left + dl, gen_right + dr, pick_rate());
            end else if (k < 88) begin
                queue_sample($urandom, $urandom, pick_rate());
            end else if (k < 94) begin
                queue_sample(32'h7FFF_FFF0 + $urandom_range(31),
                             32'h7FFF_FFF0 + $urandom_range(31), pick_rate());
            end else begin
                dl = $urandom;
                queue_sample(gen_left + (dl >>> $urandom_range(31)), gen_right, $urandom);
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // defaults: priming, still, threshold edges, wrap, IMU extremes
        queue_sample(32'h0000_0010, 32'h0000_0020, 32'h0);
        queue_sample(32'h0000_0010, 32'h0000_0020, 32'h0);
        queue_sample(32'h0000_1398, 32'h0000_0020, 32'h0001_0000);
        queue_sample(32'h0000_0010, 32'hFFFF_EC98, 32'hFFFF_0000);
        queue_sample(32'h0000_1399, 32'hFFFF_EC98, 32'h0);
        queue_sample(32'h0000_1399, 32'hFFFF_EC97, 32'h7FFF_FFFF);
        queue_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
        queue_sample(32'h8000_0100, 32'h7FFF_FF00, 32'h0);
        queue_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
        queue_sample(32'h0000_0FFF, 32'hFFFF_F001, 32'h0000_4000);
        queue_sample(32'h0000_0FFF, 32'hFFFF_F001, 32'hAAAA_5555);
        drain_wait();

        // wheel yaw with every register at its top value; pose saturates
        write_all(24'hFF_FFFF, 20'hF_FFFF, 1'b1, 31'h7FFF_FFFF, 24'hFF_FFFF);
        queue_sample(32'h0, 32'h0, 32'h5555_AAAA);
        for (int i = 0; i < 12; i++)
            queue_sample(gen_left + 32'h7FFF_FFFF, gen_right - 32'h7FFF_FFFF, $urandom);
        queue_sample(gen_left + 32'h8000_0000, gen_right, 32'h0);
        random_samples(120);
        drain_wait();

        // bottom values: zero tick, smallest reciprocal, zero threshold
        write_all(24'h0, 20'h1, 1'b1, 31'h0, 24'h0);
        queue_sample(gen_left, gen_right, 32'h7FFF_FFFF);
        queue_sample(gen_left + 1, gen_right, 32'h0);
        random_samples(100);
        drain_wait();

        write_all(24'h0, 20'h1, 1'b0, 31'h0, 24'h0);
        random_samples(80);
        drain_wait();

        // moderate settings back at the power-up state, then random ones
        write_all(24'd34561, 20'd42010, 1'b0, 31'd5000, 24'd335544);
        random_samples(250);
        drain_wait();

        for (int ph = 0; ph < 4; ph++) begin
            write_all(24'($urandom), 20'($urandom_range(20'hF_FFFF, 1)), ph[0],
                      31'($urandom_range(20000)), 24'($urandom));
            random_samples(90);
            drain_wait();
        end

        if (mismatches == 0 && pose_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
`default_nettype wire
